// File: rtl/tpg_pkg.sv
package tpg_pkg;

  // Width of every element, index and swap field on the result channel
  localparam int FIELD_W = 4;

  // Word index of the size register on the configuration port
  localparam logic REG_PERM_SIZE = 1'b0;

  // Sequencer states of the core
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_PIVOT,
    ST_LOADP,
    ST_SCAN,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_EMIT
  } state_t;

  // One result item as it travels through the read-out stage
  typedef struct packed {
    logic               last;
    logic               more_after;
    logic [FIELD_W-1:0] swap_second;
    logic [FIELD_W-1:0] swap_first;
    logic [FIELD_W-1:0] elem_value;
    logic [FIELD_W-1:0] elem_index;
  } result_t;

  // Factorial of a size of up to fifteen elements
  function automatic logic [63:0] fact_lut(input logic [3:0] k);
    logic [63:0] f;
    case (k)
      4'd0:    f = 64'd1;
      4'd1:    f = 64'd1;
      4'd2:    f = 64'd2;
      4'd3:    f = 64'd6;
      4'd4:    f = 64'd24;
      4'd5:    f = 64'd120;
      4'd6:    f = 64'd720;
      4'd7:    f = 64'd5040;
      4'd8:    f = 64'd40320;
      4'd9:    f = 64'd362880;
      4'd10:   f = 64'd3628800;
      4'd11:   f = 64'd39916800;
      4'd12:   f = 64'd479001600;
      4'd13:   f = 64'd6227020800;
      4'd14:   f = 64'd87178291200;
      default: f = 64'd1307674368000;
    endcase
    return f;
  endfunction

endpackage

// File: rtl/tpg_ram.sv
module tpg_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 12,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: rtl/tpg_radix.sv
module tpg_radix #(
  parameter int NMAX = 12,
  localparam int NW = $clog2(NMAX + 1),
  localparam int AW = $clog2(NMAX)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic          inc,
  input  logic [NW-1:0] n,
  output logic [AW-1:0] hp
);

  // Digit k has radix k+3; together the digits count the odd moves
  localparam int NDIG  = (NMAX > 2) ? NMAX - 2 : 1;
  localparam int DIG_W = $clog2(NMAX + 1);

  logic [DIG_W-1:0] dig_r   [NDIG];
  logic [DIG_W-1:0] dig_nxt [NDIG];
  logic [NDIG:0]    carry;

  // Advance the mixed-radix count by one, or clear it on restart
  always_comb begin
    carry[0] = 1'b1;
    for (int k = 0; k < NDIG; k++) begin
      carry[k+1] = carry[k] & (dig_r[k] == DIG_W'(k + 2));
      if (clr) begin
        dig_nxt[k] = '0;
      end else if (inc && carry[k]) begin
        dig_nxt[k] = (dig_r[k] == DIG_W'(k + 2)) ? '0 : dig_r[k] + DIG_W'(1);
      end else begin
        dig_nxt[k] = dig_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NDIG; k++) begin
        dig_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NDIG; k++) begin
        dig_r[k] <= dig_nxt[k];
      end
    end
  end

  // Pivot position: three plus the run of zero low digits, held at most n, minus one
  always_comb begin
    int tz;
    int h;
    tz = NDIG;
    for (int k = NDIG - 1; k >= 0; k--) begin
      if (dig_r[k] != '0) begin
        tz = k;
      end
    end
    h = tz + 3;
    if (h > int'(n)) begin
      h = int'(n);
    end
    hp = AW'(h - 1);
  end

endmodule

// File: rtl/tpg_emit.sv
module tpg_emit
  import tpg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               issue,
  input  result_t            issue_meta,
  input  logic [FIELD_W-1:0] rd_value,
  output logic               can_issue,
  output logic               out_valid,
  input  logic               out_ready,
  output result_t            out_item
);

  logic    pend_r;
  result_t pend_meta_r;
  logic    out_valid_r;
  result_t out_item_r;
  logic    skid_valid_r;
  result_t skid_item_r;

  logic    take;
  logic    push;
  result_t push_item;
  logic [1:0] occ;

  assign take = out_valid_r & out_ready;
  assign push = pend_r;

  // Merge the memory word into the fields captured when its read was issued
  always_comb begin
    push_item            = pend_meta_r;
    push_item.elem_value = rd_value;
  end

  // Allow a read only when its word is sure to find room when it arrives
  assign occ       = 2'(out_valid_r) + 2'(skid_valid_r) + 2'(pend_r);
  assign can_issue = take ? (occ <= 2'd2) : (occ <= 2'd1);

  // Track reads in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_meta_r <= issue_meta;
    end
  end

  // Output register backed by one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_item_r <= skid_item_r;
        if (push) begin
          skid_item_r <= push_item;
        end
      end else if (push) begin
        out_item_r <= push_item;
      end
    end else if (push) begin
      skid_item_r <= push_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: rtl/transposition_permutation_generator_core.sv
// Permutation generator: each request on the input stream either restarts at the identity
// order or moves one step through all n! orders of 0..n-1, each differing from the last by
// one exchange, and then streams the whole order out as n transfers with tlast on the
// final one. n is the perm_size register, held at MAX_ELEMS; change it only while idle.
// The order lives in a small RAM with registered reads, so each request is worked
// through the RAM at most one access per cycle: a restart is the accept, n identity writes,
// then n reads; an even step is the accept, the pivot read, one compare, two writes and n
// reads; an odd step is the same but compares h-1 values, where h-1 is the pivot position
// found from the mixed-radix step count and h is at most n. Results leave at one per cycle while the
// downstream side keeps up, and the next request is taken as soon as the last read of
// the current one has been issued.
module transposition_permutation_generator_core
  import tpg_pkg::*;
#(
  parameter int MAX_ELEMS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [0] restart, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [3:0] elem_index, [7:4] elem_value, [11:8] swap_first,
                                    // [15:12] swap_second, [16] more_after, [23:17] zero
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // A size register of four bits never reaches beyond fifteen elements
  localparam int NMAX  = (MAX_ELEMS < 15) ? MAX_ELEMS : 15;
  localparam int AW    = $clog2(NMAX);
  localparam int NW    = $clog2(NMAX + 1);
  localparam longint unsigned FACT_MAX = fact_lut(4'(NMAX));
  localparam int CNT_W = $clog2(FACT_MAX + 1);

  state_t             state_r, state_nxt;
  logic [3:0]         perm_size_r, perm_size_nxt;
  logic [NW-1:0]      size_used_r, size_used_nxt;
  logic [CNT_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic               even_r, even_nxt;
  logic               more_r, more_nxt;
  logic               ev_move_r, ev_move_nxt;
  logic [NW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      hp_r, hp_nxt;
  logic [AW-1:0]      pivot_r, pivot_nxt;
  logic [NW-1:0]      best_r, best_nxt;
  logic [AW-1:0]      bval_r, bval_nxt;
  logic [AW-1:0]      bpos_r, bpos_nxt;
  logic [AW-1:0]      sx_r, sx_nxt;
  logic [AW-1:0]      sy_r, sy_nxt;

  logic               in_accept;
  logic               cfg_write;
  logic [NW-1:0]      n_cur;
  logic [CNT_W-1:0]   fact_cur;
  logic               restart_req;
  logic               last_idx;
  logic               scan_end;
  logic [AW-1:0]      hp_sel;
  logic [NW-1:0]      dist_mod;
  logic [NW:0]        dist_wide;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [AW-1:0]      ram_rdata;

  logic               radix_clr;
  logic               radix_inc;
  logic [AW-1:0]      radix_hp;

  logic               issue;
  logic               can_issue;
  result_t            issue_meta;
  result_t            out_item;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_PERM_SIZE) ? {28'd0, perm_size_r} : 32'd0;

  // Effective size and restart decision for the request on offer
  assign n_cur       = (int'(perm_size_r) > MAX_ELEMS) ? NW'(NMAX) : NW'(perm_size_r);
  assign fact_cur    = CNT_W'(fact_lut(4'(n_cur)));
  assign in_accept   = in_tvalid & in_tready;
  assign restart_req = in_tdata[0] | (n_cur != size_used_r) | ~more_r;

  assign last_idx = (cnt_r == size_used_r - NW'(1));
  assign scan_end = (cnt_r[AW-1:0] == hp_r - AW'(1));
  assign hp_sel   = ev_move_r ? AW'(1) : radix_hp;

  // Distance from the pivot value up to a scanned value, modulo n
  always_comb begin
    if (ram_rdata >= pivot_r) begin
      dist_wide = (NW+1)'(ram_rdata) - (NW+1)'(pivot_r);
    end else begin
      dist_wide = (NW+1)'(ram_rdata) + (NW+1)'(size_used_r) - (NW+1)'(pivot_r);
    end
    dist_mod = NW'(dist_wide);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = restart_req ? ST_INIT : ST_PIVOT;
        end
      end
      ST_INIT: begin
        if (size_used_r == '0 || last_idx) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_PIVOT:  state_nxt = ST_LOADP;
      ST_LOADP:  state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_SWAP_A;
        end
      end
      ST_SWAP_A: state_nxt = ST_SWAP_B;
      ST_SWAP_B: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (size_used_r == '0 || (issue && last_idx)) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Memory accesses, read-out issue and counter control per state
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    issue     = 1'b0;
    radix_clr = 1'b0;
    radix_inc = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        radix_clr = in_accept & restart_req;
        radix_inc = in_accept & ~restart_req & ~even_r;
      end
      ST_INIT: begin
        ram_we    = (size_used_r != '0);
        ram_waddr = cnt_r[AW-1:0];
        ram_wdata = cnt_r[AW-1:0];
      end
      ST_PIVOT: begin
        ram_raddr = hp_sel;
      end
      ST_LOADP: begin
        ram_raddr = '0;
      end
      ST_SCAN: begin
        ram_raddr = cnt_r[AW-1:0] + AW'(1);
      end
      ST_SWAP_A: begin
        ram_we    = 1'b1;
        ram_waddr = hp_r;
        ram_wdata = bval_r;
      end
      ST_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = bpos_r;
        ram_wdata = pivot_r;
      end
      ST_EMIT: begin
        ram_raddr = cnt_r[AW-1:0];
        issue     = (size_used_r != '0) & can_issue;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Fields of the result whose element is being read
  always_comb begin
    issue_meta             = '0;
    issue_meta.elem_index  = FIELD_W'(cnt_r[AW-1:0]);
    issue_meta.swap_first  = FIELD_W'(sx_r);
    issue_meta.swap_second = FIELD_W'(sy_r);
    issue_meta.more_after  = more_r;
    issue_meta.last        = last_idx;
  end

  // Sequence counters, scan registers and the size register
  always_comb begin
    perm_size_nxt = perm_size_r;
    size_used_nxt = size_used_r;
    step_nxt      = step_r;
    total_nxt     = total_r;
    even_nxt      = even_r;
    more_nxt      = more_r;
    ev_move_nxt   = ev_move_r;
    cnt_nxt       = cnt_r;
    hp_nxt        = hp_r;
    pivot_nxt     = pivot_r;
    best_nxt      = best_r;
    bval_nxt      = bval_r;
    bpos_nxt      = bpos_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;

    if (cfg_write && cfg_paddr[2] == REG_PERM_SIZE) begin
      perm_size_nxt = cfg_pwdata[3:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          cnt_nxt     = '0;
          ev_move_nxt = even_r;
          if (restart_req) begin
            size_used_nxt = n_cur;
            total_nxt     = fact_cur;
            step_nxt      = CNT_W'(1);
            even_nxt      = 1'b1;
            more_nxt      = (fact_cur != CNT_W'(1));
            sx_nxt        = '0;
            sy_nxt        = '0;
          end else if (even_r) begin
            even_nxt = 1'b0;
            step_nxt = step_r + CNT_W'(1);
            more_nxt = (step_r + CNT_W'(1) != total_r);
          end else begin
            even_nxt = 1'b1;
            step_nxt = step_r + CNT_W'(1);
          end
        end
      end
      ST_INIT: begin
        cnt_nxt = last_idx ? '0 : cnt_r + NW'(1);
      end
      ST_PIVOT: begin
        hp_nxt = hp_sel;
      end
      ST_LOADP: begin
        pivot_nxt = ram_rdata;
        best_nxt  = size_used_r;
        cnt_nxt   = '0;
      end
      ST_SCAN: begin
        // First nearest value wins
        if (dist_mod < best_r) begin
          best_nxt = dist_mod;
          bval_nxt = ram_rdata;
          bpos_nxt = cnt_r[AW-1:0];
        end
        if (!scan_end) begin
          cnt_nxt = cnt_r + NW'(1);
        end
      end
      ST_SWAP_A: begin
        if (ev_move_r) begin
          sx_nxt = pivot_r;
          sy_nxt = bval_r;
        end else begin
          sx_nxt = bval_r;
          sy_nxt = pivot_r;
        end
      end
      ST_SWAP_B: begin
        cnt_nxt = '0;
      end
      ST_EMIT: begin
        if (issue) begin
          cnt_nxt = last_idx ? '0 : cnt_r + NW'(1);
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      perm_size_r <= 4'd1;
      size_used_r <= '0;
      step_r      <= '0;
      total_r     <= '0;
      even_r      <= 1'b1;
      more_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      perm_size_r <= perm_size_nxt;
      size_used_r <= size_used_nxt;
      step_r      <= step_nxt;
      total_r     <= total_nxt;
      even_r      <= even_nxt;
      more_r      <= more_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Working registers of the current step
  always_ff @(posedge clk) begin
    ev_move_r <= ev_move_nxt;
    hp_r      <= hp_nxt;
    pivot_r   <= pivot_nxt;
    best_r    <= best_nxt;
    bval_r    <= bval_nxt;
    bpos_r    <= bpos_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
  end

  // Current order; the swap writes always land before the read-out starts
  tpg_ram #(
    .WIDTH (AW),
    .DEPTH (NMAX)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tpg_radix #(
    .NMAX (NMAX)
  ) u_radix (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (radix_clr),
    .inc   (radix_inc),
    .n     (size_used_r),
    .hp    (radix_hp)
  );

  tpg_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .issue_meta (issue_meta),
    .rd_value   (FIELD_W'(ram_rdata)),
    .can_issue  (can_issue),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_item   (out_item)
  );

  // Pack the result channel
  assign out_tdata = {7'd0, out_item.more_after, out_item.swap_second, out_item.swap_first,
                      out_item.elem_value, out_item.elem_index};
  assign out_tlast = out_item.last;

endmodule

// File: rtl/tpg_chk.sv
module tpg_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  logic       xfer;
  logic [3:0] exp_idx_r, exp_idx_nxt;
  logic       mid_run_r, mid_run_nxt;
  logic [8:0] run_hdr_r, run_hdr_nxt;

  assign xfer = out_tvalid & out_tready;

  // Follow the position count and the per-step fields of the run in progress
  always_comb begin
    exp_idx_nxt = exp_idx_r;
    mid_run_nxt = mid_run_r;
    run_hdr_nxt = run_hdr_r;
    if (xfer) begin
      exp_idx_nxt = out_tlast ? 4'd0 : out_tdata[3:0] + 4'd1;
      mid_run_nxt = ~out_tlast;
      run_hdr_nxt = out_tdata[16:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= 4'd0;
      mid_run_r <= 1'b0;
      run_hdr_r <= 9'd0;
    end else begin
      exp_idx_r <= exp_idx_nxt;
      mid_run_r <= mid_run_nxt;
      run_hdr_r <= run_hdr_nxt;
    end
  end

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Positions run from zero upwards within each run
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |-> out_tdata[3:0] == exp_idx_r)
    else $error("position out of sequence");

  // A step exchanges two distinct values, a restart reports none
  a_swap: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |-> (out_tdata[11:8] != out_tdata[15:12])
          || (out_tdata[11:8] == 4'd0 && out_tdata[15:12] == 4'd0))
    else $error("swap fields inconsistent");

  // Swap fields and the more flag stay fixed over one run
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && mid_run_r |-> out_tdata[16:8] == run_hdr_r)
    else $error("per-step fields changed within a run");

endmodule

bind transposition_permutation_generator_core tpg_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
